>>> rtl/slfp_pkg.sv
// shared types and constants of the strip level first-fit placer
`default_nettype none

package slfp_pkg;

    localparam int CEIL_BITS = 18;
    localparam logic [CEIL_BITS-1:0] CEIL_MAX = '1;
    localparam int STRIP_RESET = 1024;

    localparam logic CFG_STRIP_WIDTH = 1'b0;
    localparam logic CFG_ROTATE_MODE = 1'b1;

    localparam logic [1:0] ROT_FLAT = 2'd1;
    localparam logic [1:0] ROT_UPRIGHT = 2'd2;

    typedef enum logic [1:0] {
        STATUS_PLACED = 2'd0,
        STATUS_WIDE = 2'd1,
        STATUS_FULL = 2'd2
    } slfp_status_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } slfp_state_t;

    typedef struct packed {
        logic shift;
        logic clear;
        logic commit;
        logic open;
    } slfp_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/strip_level_first_fit_placer.sv
// top level: first-fit decreasing height strip placer over a chain of level cells
//
//  channel   dir  handshake                    contents
//  s_axis    in   s_axis_tvalid/s_axis_tready  rectangle size, start_new in tuser
//  m_axis    out  m_axis_tvalid/m_axis_tready  position, placed size, ceiling, status
//  cfg       in   cfg_we                       strip_width (0), rotate_mode (1)
//
// an item is taken while idle, then the search token walks down the chain one level
// cell at a time until a level fits the item or a new level opens past the last one
// reset clears level count, ceiling, token and output valid; no clearing pass
// a finished result waits in the output register while the next item is taken;
// the last search step holds until that register is free
`default_nettype none

module strip_level_first_fit_placer #(
    parameter int MAX_LEVELS = 64,
    parameter int DIM_BITS = 12
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // rect_width, rect_height
    input  wire logic [((2*DIM_BITS+7)/8)*8-1:0] s_axis_tdata,
    // start_new
    input  wire logic                       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // place_x, place_y, placed_width, placed_height, total_height
    output logic [((3*DIM_BITS+2*slfp_pkg::CEIL_BITS+7)/8)*8-1:0] m_axis_tdata,
    // status
    output logic [1:0]                      m_axis_tuser,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [DIM_BITS-1:0]        cfg_data
);

    localparam int CB = slfp_pkg::CEIL_BITS;
    localparam int CNT_BITS = $clog2(MAX_LEVELS + 1);
    localparam int IDX_BITS = $clog2(MAX_LEVELS);
    localparam int OUT_BITS = ((3*DIM_BITS + 2*CB + 7) / 8) * 8;

    slfp_pkg::slfp_state_t   state_reg, state_next;
    slfp_pkg::slfp_ctrl_t    ctrl;

    logic [DIM_BITS-1:0]     strip_reg, strip_next;
    logic [1:0]              mode_reg, mode_next;
    logic [DIM_BITS-1:0]     w_reg, w_next, h_reg, h_next;
    logic [CNT_BITS-1:0]     count_reg, count_next;
    logic [CNT_BITS-1:0]     pos_reg, pos_next;
    logic [CB-1:0]           ceil_reg, ceil_next;

    logic                    out_valid_reg, out_valid_next;
    logic [DIM_BITS-1:0]     x_reg, x_next;
    logic [CB-1:0]           y_reg, y_next;
    logic [DIM_BITS-1:0]     pw_reg, ph_reg;
    logic [CB-1:0]           total_reg, total_next;
    slfp_pkg::slfp_status_t  status_reg, status_next;
    logic                    out_load;

    logic [DIM_BITS-1:0]     in_w, in_h;
    logic                    swap;
    logic [CB:0]             ceil_sum;
    logic [CB-1:0]           ceil_grown;
    logic                    out_free;

    logic [MAX_LEVELS:0]     tok_chain;
    logic [MAX_LEVELS-1:0]   hit_vec;
    logic [DIM_BITS-1:0]     used_arr [MAX_LEVELS];
    logic [CB-1:0]           base_arr [MAX_LEVELS];

    assign in_w = s_axis_tdata[DIM_BITS-1:0];
    assign in_h = s_axis_tdata[2*DIM_BITS-1:DIM_BITS];
    assign swap = (mode_reg == slfp_pkg::ROT_FLAT && in_w < in_h) ||
                  (mode_reg == slfp_pkg::ROT_UPRIGHT && in_w > in_h);

    assign ceil_sum = {1'b0, ceil_reg} + (CB + 1)'(h_reg);
    assign ceil_grown = (ceil_sum > {1'b0, slfp_pkg::CEIL_MAX}) ?
                        slfp_pkg::CEIL_MAX : ceil_sum[CB-1:0];
    assign out_free = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == slfp_pkg::ST_IDLE);
    assign tok_chain[0] = s_axis_tvalid && s_axis_tready;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_LEVELS; gi++)
        begin : g_cell
            slfp_cell #(
                .DIM_BITS(DIM_BITS)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .tok_in  (tok_chain[gi]),
                .item_w  (w_reg),
                .item_h  (h_reg),
                .strip_w (strip_reg),
                .ceil_in (ceil_reg),
                .tok_out (tok_chain[gi+1]),
                .hit     (hit_vec[gi]),
                .used_w  (used_arr[gi]),
                .base    (base_arr[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        ctrl = '0;
        strip_next = strip_reg;
        mode_next = mode_reg;
        w_next = w_reg;
        h_next = h_reg;
        count_next = count_reg;
        pos_next = pos_reg;
        ceil_next = ceil_reg;
        out_load = 1'b0;
        x_next = '0;
        y_next = '0;
        total_next = ceil_reg;
        status_next = slfp_pkg::STATUS_PLACED;

        if (cfg_we)
        begin
            case (cfg_index)
                slfp_pkg::CFG_STRIP_WIDTH: strip_next = cfg_data;
                slfp_pkg::CFG_ROTATE_MODE: mode_next = cfg_data[1:0];
                default: ;
            endcase
        end

        case (state_reg)
            slfp_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    ctrl.shift = 1'b1;
                    w_next = swap ? in_h : in_w;
                    h_next = swap ? in_w : in_h;
                    pos_next = '0;
                    if (s_axis_tuser)
                    begin
                        count_next = '0;
                        ceil_next = '0;
                    end
                    state_next = slfp_pkg::ST_SEARCH;
                end
            end
            slfp_pkg::ST_SEARCH:
            begin
                if (pos_reg == count_reg)
                begin
                    if (out_free)
                    begin
                        ctrl.clear = 1'b1;
                        out_load = 1'b1;
                        state_next = slfp_pkg::ST_IDLE;
                        if (count_reg == CNT_BITS'(MAX_LEVELS))
                        begin
                            status_next = slfp_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            ctrl.commit = 1'b1;
                            ctrl.open = 1'b1;
                            count_next = count_reg + 1'b1;
                            ceil_next = ceil_grown;
                            y_next = ceil_reg;
                            total_next = ceil_grown;
                            if (w_reg > strip_reg)
                                status_next = slfp_pkg::STATUS_WIDE;
                        end
                    end
                end
                else if (|hit_vec)
                begin
                    if (out_free)
                    begin
                        ctrl.clear = 1'b1;
                        ctrl.commit = 1'b1;
                        out_load = 1'b1;
                        x_next = used_arr[pos_reg[IDX_BITS-1:0]];
                        y_next = base_arr[pos_reg[IDX_BITS-1:0]];
                        state_next = slfp_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    ctrl.shift = 1'b1;
                    pos_next = pos_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = slfp_pkg::ST_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= slfp_pkg::ST_IDLE;
            strip_reg <= DIM_BITS'(slfp_pkg::STRIP_RESET);
            mode_reg <= '0;
            count_reg <= '0;
            pos_reg <= '0;
            ceil_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            strip_reg <= strip_next;
            mode_reg <= mode_next;
            count_reg <= count_next;
            pos_reg <= pos_next;
            ceil_reg <= ceil_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        h_reg <= h_next;
        if (out_load)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            pw_reg <= w_reg;
            ph_reg <= h_reg;
            total_reg <= total_next;
            status_reg <= status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = OUT_BITS'({total_reg, ph_reg, pw_reg, y_reg, x_reg});
    assign m_axis_tuser = status_reg;

    // at most one cell carries the search token
    a_token_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_chain[MAX_LEVELS:1]))
        else $error("more than one search token in the level chain");

    // the search never runs past the open levels
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == slfp_pkg::ST_SEARCH |-> pos_reg <= count_reg)
        else $error("search position beyond level count");

    // a full table leaves the level count alone
    a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && status_next == slfp_pkg::STATUS_FULL |=>
        count_reg == $past(count_reg) && ceil_reg == $past(ceil_reg))
        else $error("level state changed on a full table");

    // a finished result is never dropped onto a waiting one
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !out_valid_reg || m_axis_tready)
        else $error("result loaded while output still held");

endmodule

`default_nettype wire

>>> rtl/slfp_cell.sv
// one level cell: holds a level and checks the item under the token
`default_nettype none

module slfp_cell #(
    parameter int DIM_BITS = 12
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire slfp_pkg::slfp_ctrl_t         ctrl,
    input  wire logic                         tok_in,
    input  wire logic [DIM_BITS-1:0]          item_w,
    input  wire logic [DIM_BITS-1:0]          item_h,
    input  wire logic [DIM_BITS-1:0]          strip_w,
    input  wire logic [slfp_pkg::CEIL_BITS-1:0] ceil_in,
    output logic                              tok_out,
    output logic                              hit,
    output logic [DIM_BITS-1:0]               used_w,
    output logic [slfp_pkg::CEIL_BITS-1:0]    base
);

    logic                            tok_reg, tok_next;
    logic [DIM_BITS-1:0]             used_reg, used_next;
    logic [DIM_BITS-1:0]             last_reg, last_next;
    logic [slfp_pkg::CEIL_BITS-1:0]  base_reg, base_next;
    logic [DIM_BITS:0]               sum;
    logic                            fit;
    logic                            write;

    assign sum = {1'b0, used_reg} + {1'b0, item_w};
    assign fit = (last_reg >= item_h) && (sum <= {1'b0, strip_w});
    assign write = tok_reg && ctrl.commit && (ctrl.open || fit);

    always_comb
    begin
        if (ctrl.shift)
            tok_next = tok_in;
        else if (ctrl.clear)
            tok_next = 1'b0;
        else
            tok_next = tok_reg;

        used_next = used_reg;
        last_next = last_reg;
        base_next = base_reg;
        if (write)
        begin
            last_next = item_h;
            if (ctrl.open)
            begin
                used_next = item_w;
                base_next = ceil_in;
            end
            else
            begin
                used_next = sum[DIM_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= 1'b0;
        else
            tok_reg <= tok_next;
    end

    always_ff @(posedge clk)
    begin
        used_reg <= used_next;
        last_reg <= last_next;
        base_reg <= base_next;
    end

    assign tok_out = tok_reg;
    assign hit = tok_reg && fit;
    assign used_w = used_reg;
    assign base = base_reg;

endmodule

`default_nettype wire

>>> tb/strip_level_first_fit_placer_tb.sv
// testbench of the strip level first-fit placer: directed and random rectangle sets
`default_nettype none

module strip_level_first_fit_placer_tb;

    localparam int LEVELS = 64;
    localparam int DIM = 12;
    localparam int CB = slfp_pkg::CEIL_BITS;

    typedef struct {
        logic [DIM-1:0]         x;
        logic [CB-1:0]          y;
        logic [DIM-1:0]         w;
        logic [DIM-1:0]         h;
        logic [CB-1:0]          top;
        slfp_pkg::slfp_status_t status;
    } placement_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [DIM-1:0] cfg_data = '0;

    strip_level_first_fit_placer #(
        .MAX_LEVELS(LEVELS),
        .DIM_BITS(DIM)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        // rect_width, rect_height
        .s_axis_tdata(s_axis_tdata),
        // start_new
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        // place_x, place_y, placed_width, placed_height, total_height
        .m_axis_tdata(m_axis_tdata),
        // status
        .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [DIM-1:0]       strip_w = DIM'(slfp_pkg::STRIP_RESET);
    logic [1:0]           rot_mode = 2'd0;
    logic [DIM-1:0]       level_fill [LEVELS];
    logic [CB-1:0]        level_floor [LEVELS];
    logic [DIM-1:0]       level_top_h [LEVELS];
    int                   level_total = 0;
    logic [CB-1:0]        stack_top = '0;

    placement_t pending_places [$];
    bit steady = 1'b0;
    int err_count = 0;
    int sent = 0;
    int sets_sent = 0;
    int checked = 0;
    int wide_seen = 0;
    int full_seen = 0;

    function automatic placement_t place_rect(input logic [DIM-1:0] w_in,
                                              input logic [DIM-1:0] h_in,
                                              input logic fresh);
        placement_t r;
        logic [DIM-1:0] w;
        logic [DIM-1:0] h;
        logic [CB:0] next_top;
        bit found;
        int j;
        if (fresh)
        begin
            level_total = 0;
            stack_top = '0;
        end
        w = w_in;
        h = h_in;
        if ((rot_mode == slfp_pkg::ROT_FLAT && w_in < h_in) ||
            (rot_mode == slfp_pkg::ROT_UPRIGHT && w_in > h_in))
        begin
            w = h_in;
            h = w_in;
        end
        r.x = '0;
        r.y = '0;
        r.status = slfp_pkg::STATUS_PLACED;
        found = 1'b0;
        for (j = 0; j < level_total; j++)
        begin
            if (!found && level_top_h[j] >= h &&
                {1'b0, level_fill[j]} + {1'b0, w} <= {1'b0, strip_w})
            begin
                r.x = level_fill[j];
                r.y = level_floor[j];
                level_top_h[j] = h;
                level_fill[j] = level_fill[j] + w;
                found = 1'b1;
            end
        end
        if (!found)
        begin
            if (level_total >= LEVELS)
                r.status = slfp_pkg::STATUS_FULL;
            else
            begin
                r.y = stack_top;
                level_floor[level_total] = stack_top;
                level_fill[level_total] = w;
                level_top_h[level_total] = h;
                level_total++;
                next_top = {1'b0, stack_top} + h;
                stack_top = (next_top > slfp_pkg::CEIL_MAX) ?
                            slfp_pkg::CEIL_MAX : next_top[CB-1:0];
                if (w > strip_w)
                    r.status = slfp_pkg::STATUS_WIDE;
            end
        end
        r.w = w;
        r.h = h;
        r.top = stack_top;
        return r;
    endfunction

    task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch in result %0d, %s: got %0d expected %0d", checked, what, got, want);
        err_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag(what, got, want);
    endtask

    always @(posedge clk)
    begin
        placement_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_places.size() == 0)
                flag("result with nothing pending", 32'(m_axis_tuser), 0);
            else
            begin
                want = pending_places.pop_front();
                check_field("place_x", 32'(m_axis_tdata[11:0]), 32'(want.x));
                check_field("place_y", 32'(m_axis_tdata[29:12]), 32'(want.y));
                check_field("placed_width", 32'(m_axis_tdata[41:30]), 32'(want.w));
                check_field("placed_height", 32'(m_axis_tdata[53:42]), 32'(want.h));
                check_field("total_height", 32'(m_axis_tdata[71:54]), 32'(want.top));
                check_field("status", 32'(m_axis_tuser), 32'(want.status));
                if (want.status == slfp_pkg::STATUS_WIDE)
                    wide_seen++;
                if (want.status == slfp_pkg::STATUS_FULL)
                    full_seen++;
            end
            checked++;
        end
        m_axis_tready <= steady || ($urandom_range(99) >= 24);
    end

    task automatic push_rect(input logic [DIM-1:0] w, input logic [DIM-1:0] h,
                             input logic fresh);
        while (!steady && $urandom_range(99) < 24)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {h, w};
        s_axis_tuser <= fresh;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_places.insert(pending_places.size(), place_rect(w, h, fresh));
        sent++;
        if (fresh)
            sets_sent++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_places.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [DIM-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == slfp_pkg::CFG_STRIP_WIDTH)
            strip_w = val;
        else
            rot_mode = val[1:0];
    endtask

    task automatic test_reset_config();
        push_rect(12'd4095, 12'd4095, 1'b1);
        push_rect(12'd0, 12'd0, 1'b0);
        push_rect(12'd1024, 12'd900, 1'b1);
        push_rect(12'd1, 12'd900, 1'b0);
        push_rect(12'd600, 12'd800, 1'b0);
        push_rect(12'd424, 12'd800, 1'b0);
        push_rect(12'd0, 12'd700, 1'b0);
        push_rect(12'd1023, 12'd1000, 1'b0);
        push_rect(12'd1, 12'd0, 1'b0);
        settle();
    endtask

    task automatic test_rotation();
        write_reg(slfp_pkg::CFG_STRIP_WIDTH, 12'd4095);
        write_reg(slfp_pkg::CFG_ROTATE_MODE, 12'hFFD);
        push_rect(12'd10, 12'd300, 1'b1);
        push_rect(12'd300, 12'd10, 1'b0);
        push_rect(12'd50, 12'd50, 1'b0);
        settle();
        write_reg(slfp_pkg::CFG_ROTATE_MODE, {10'd0, slfp_pkg::ROT_UPRIGHT});
        push_rect(12'd10, 12'd300, 1'b1);
        push_rect(12'd300, 12'd10, 1'b0);
        push_rect(12'd4095, 12'd0, 1'b0);
        settle();
        write_reg(slfp_pkg::CFG_ROTATE_MODE, 12'd3);
        push_rect(12'd10, 12'd300, 1'b1);
        push_rect(12'd300, 12'd10, 1'b0);
        settle();
        write_reg(slfp_pkg::CFG_STRIP_WIDTH, 12'd1);
        write_reg(slfp_pkg::CFG_ROTATE_MODE, 12'd0);
        push_rect(12'd1, 12'd5, 1'b1);
        push_rect(12'd0, 12'd5, 1'b0);
        push_rect(12'd2, 12'd4, 1'b0);
        push_rect(12'd1, 12'd4, 1'b0);
        settle();
    endtask

    task automatic test_table_full();
        int j;
        write_reg(slfp_pkg::CFG_STRIP_WIDTH, 12'd1);
        write_reg(slfp_pkg::CFG_ROTATE_MODE, 12'd0);
        for (j = 0; j < LEVELS + 2; j++)
            push_rect(12'd1, 12'(4095 - j), j == 0);
        push_rect(12'd0, 12'd3000, 1'b0);
        push_rect(12'd1, 12'd5, 1'b1);
        settle();
    endtask

    task automatic send_set(input int sw);
        int n;
        int i;
        int hv;
        int cap;
        bit noisy;
        logic [DIM-1:0] w;
        logic [DIM-1:0] h;
        n = ($urandom_range(9) == 0) ? $urandom_range(64, 90) : $urandom_range(1, 40);
        noisy = ($urandom_range(9) == 0);
        hv = $urandom_range(1) ? $urandom_range(4095) : $urandom_range(300);
        cap = (sw <= 16) ? sw : sw / 3;
        for (i = 0; i < n; i++)
        begin
            if (noisy)
            begin
                w = DIM'($urandom);
                h = DIM'($urandom);
                push_rect(w, h, (i == 0) || ($urandom_range(19) == 0));
            end
            else
            begin
                if ($urandom_range(15) == 0)
                    w = DIM'($urandom_range(4095));
                else if (sw <= 16 && $urandom_range(3) != 0)
                    w = DIM'(sw);
                else
                    w = DIM'($urandom_range(cap));
                h = DIM'(hv);
                push_rect(w, h, i == 0);
                hv = hv - $urandom_range(0, (hv < 200) ? hv : 200);
            end
        end
    endtask

    task automatic test_random_sets();
        int ph;
        int sw;
        int first;
        for (ph = 0; ph < 14; ph++)
        begin
            settle();
            case (ph % 7)
                0: sw = 1;
                1: sw = 4095;
                2: sw = $urandom_range(2, 16);
                3: sw = $urandom_range(17, 255);
                4: sw = 1024;
                default: sw = $urandom_range(256, 4095);
            endcase
            write_reg(slfp_pkg::CFG_STRIP_WIDTH, DIM'(sw));
            write_reg(slfp_pkg::CFG_ROTATE_MODE, DIM'(ph % 4));
            steady = (ph == 5);
            first = sent;
            while (sent - first < 100)
                send_set(sw);
        end
        steady = 1'b0;
        settle();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_config();
        test_rotation();
        test_table_full();
        test_random_sets();
        repeat (80) @(posedge clk);
        $display("covered %0d rectangles in %0d sets under 4 rotation modes",
                 sent, sets_sent);
        $display("strip widths 1 to 4095, results checked %0d, too wide %0d, table full %0d",
                 checked, wide_seen, full_seen);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d results pending", pending_places.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
